### rtl/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg
// Shared constants for the spectrum peak region finder: register indexes,
// register resets, result field widths and the result beat layout.
// ----------------------------------------------------------------------------
package spf_pkg;

  // configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD_FACTOR = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_REGION_PERCENT   = 1'd1;

  // register widths and reset values
  localparam int FACT_W = 14;
  localparam int PCT_W  = 7;
  localparam int CFG_DATA_W = FACT_W;
  localparam logic [FACT_W-1:0] FACT_RESET = 14'd585;
  localparam logic [PCT_W-1:0]  PCT_RESET  = 7'd5;

  // percent scale used on the count side of both compares
  localparam int PCT_SCALE = 100;

  // result field widths
  localparam int CHAN_OUT_W  = 12;
  localparam int PCNT_OUT_W  = 24;
  localparam int AREA_OUT_W  = 36;
  localparam int WIDTH_OUT_W = 13;

  localparam int OUT_FIELDS_W = 3 * CHAN_OUT_W + PCNT_OUT_W + AREA_OUT_W + WIDTH_OUT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

endpackage

### rtl/spf_store.sv
// ----------------------------------------------------------------------------
// spf_store
// Spectrum channel memory: one write port, one read port and registered
// read data.
// ----------------------------------------------------------------------------
module spf_store #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 24
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/spf_wmul.sv
// ----------------------------------------------------------------------------
// spf_wmul
// Wide by narrow multiplier: two half-width partial products are registered
// first, then their shifted sum is registered. Shared by the threshold and
// region compare setup.
// ----------------------------------------------------------------------------
module spf_wmul #(
  parameter int A_W = 37
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [A_W-1:0]                a_i,
  input  logic [spf_pkg::FACT_W-1:0]    b_i,
  output logic                          done_o,
  output logic [A_W+spf_pkg::FACT_W-1:0] prod_o
);

  localparam int B_W  = spf_pkg::FACT_W;
  localparam int LO_W = (A_W + 1) / 2;
  localparam int HI_W = A_W - LO_W;
  localparam int P_W  = A_W + B_W;

  logic [LO_W+B_W-1:0] p_lo_q;
  logic [HI_W+B_W-1:0] p_hi_q;
  logic [P_W-1:0]      prod_q;
  logic                part_v_q;
  logic                done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_v_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      part_v_q <= start_i;
      done_q   <= part_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p_lo_q <= (LO_W+B_W)'(a_i[LO_W-1:0]) * (LO_W+B_W)'(b_i);
      p_hi_q <= (HI_W+B_W)'(a_i[A_W-1:LO_W]) * (HI_W+B_W)'(b_i);
    end
    if (part_v_q) begin
      prod_q <= (P_W'(p_hi_q) << LO_W) + P_W'(p_lo_q);
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

### rtl/spectrum_peak_region_finder.sv
// ----------------------------------------------------------------------------
// spectrum_peak_region_finder
// Photopeak search over a loaded spectrum of channel counts.
// ----------------------------------------------------------------------------
// Channel counts stream in one beat per cycle while the block is loading and
// are kept in a spectrum memory with one write port and one read port (no
// clearing after reset; only channels of the current spectrum are read). The
// beat flagged tlast ends the spectrum; the block then stops taking beats and
// makes one or two passes over the memory through its read port: a pass over
// all n stored channels marks channels above mean * factor / 100 and keeps
// the best contiguous run; if a run was found, a pass over the L channels of
// that run finds peak and region. Each pass waits first on a multiply for
// its compare threshold. The result sits in an output register, so loading
// of the next spectrum goes on while it waits; a second result waits for the
// first to be taken. Channels past MAX_CHANNELS are dropped.
// ----------------------------------------------------------------------------
module spectrum_peak_region_finder #(
  parameter int MAX_CHANNELS = 4096,
  parameter int COUNT_BITS   = 24
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic                              cfg_we_i,
  input  logic [spf_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [spf_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,

  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // channel_count
  input  logic [((COUNT_BITS+7)/8)*8-1:0]   s_axis_tdata_i,
  input  logic                              s_axis_tlast_i,

  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // left_bound, right_bound, peak_channel, peak_count, region_area, region_width
  output logic [spf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // peak_found
  output logic                              m_axis_tuser_o
);

  localparam int IDX_W = $clog2(MAX_CHANNELS);
  localparam int N_W   = $clog2(MAX_CHANNELS + 1);
  localparam int TOT_W = COUNT_BITS + N_W;
  localparam int K_W   = N_W + 7;
  localparam int PR_W  = COUNT_BITS + K_W;
  localparam int RH_W  = TOT_W + spf_pkg::FACT_W;
  localparam int ChW   = spf_pkg::CHAN_OUT_W;
  localparam int PcW   = spf_pkg::PCNT_OUT_W;
  localparam int ArW   = spf_pkg::AREA_OUT_W;
  localparam int WdW   = spf_pkg::WIDTH_OUT_W;
  localparam int PadW  = spf_pkg::OUT_PAD_W;

  typedef enum logic [3:0] {
    S_LOAD, S_TMUL, S_TWAIT, S_SCAN, S_CLOSE, S_RMUL, S_RWAIT, S_PEAK, S_EMIT
  } state_e;

  state_e state_q;

  // configuration
  logic [spf_pkg::FACT_W-1:0] factor_q;
  logic [spf_pkg::PCT_W-1:0]  pct_q;

  // load side
  logic [N_W-1:0]        loaded_q;
  logic [TOT_W-1:0]      total_q;
  logic [COUNT_BITS-1:0] in_cnt;
  logic                  in_beat;
  logic                  store_we;

  // read pipeline
  logic [N_W-1:0]        rd_idx_q;
  logic [N_W-1:0]        rd_end_q;
  logic                  rd_en;
  logic [COUNT_BITS-1:0] rdata;
  logic                  s1_v_q;
  logic [IDX_W-1:0]      s1_idx_q;
  logic                  s2_v_q;
  logic [IDX_W-1:0]      s2_idx_q;
  logic [COUNT_BITS-1:0] s2_c_q;
  logic [PR_W-1:0]       s2_prod_q;
  logic [K_W-1:0]        kscale_q;
  logic [K_W-1:0]        mop;
  logic                  drained;

  // run search
  logic                  in_run_q;
  logic                  found_q;
  logic [IDX_W-1:0]      run_start_q;
  logic [TOT_W-1:0]      run_sum_q;
  logic [IDX_W-1:0]      best_lo_q;
  logic [IDX_W-1:0]      best_hi_q;
  logic [TOT_W-1:0]      best_sum_q;
  logic                  marked;

  // peak and region
  logic                  pk_first_q;
  logic [IDX_W-1:0]      peak_q;
  logic [COUNT_BITS-1:0] peak_cnt_q;
  logic                  any_q;
  logic [IDX_W-1:0]      left_q;
  logic [IDX_W-1:0]      right_q;
  logic [TOT_W-1:0]      area_q;
  logic [N_W-1:0]        width_q;
  logic                  in_region;

  // shared multiplier
  logic                       mul_start;
  logic [TOT_W-1:0]           mul_a;
  logic [spf_pkg::FACT_W-1:0] mul_b;
  logic                       mul_done;
  logic [RH_W-1:0]            mul_prod;

  // result register
  logic                            out_v_q;
  logic                            out_found_q;
  logic [spf_pkg::OUT_TDATA_W-1:0] out_data_q;
  logic                            out_free;
  logic [spf_pkg::OUT_TDATA_W-1:0] out_data_d;

  assign s_axis_tready_o = (state_q == S_LOAD);
  assign in_beat  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_cnt   = s_axis_tdata_i[COUNT_BITS-1:0];
  assign store_we = in_beat && (loaded_q < N_W'(MAX_CHANNELS));

  assign rd_en   = ((state_q == S_SCAN) || (state_q == S_PEAK)) && (rd_idx_q != rd_end_q);
  assign drained = (rd_idx_q == rd_end_q) && !s1_v_q && !s2_v_q;
  assign mop     = (state_q == S_PEAK) ? K_W'(spf_pkg::PCT_SCALE) : kscale_q;

  assign marked    = RH_W'(s2_prod_q) > mul_prod;
  assign in_region = RH_W'(s2_prod_q) > mul_prod;

  assign mul_start = (state_q == S_TMUL) || (state_q == S_RMUL);
  assign mul_a     = (state_q == S_RMUL) ? best_sum_q : total_q;
  assign mul_b     = (state_q == S_RMUL) ? spf_pkg::FACT_W'(pct_q) : factor_q;

  assign out_free = !out_v_q || m_axis_tready_i;

  always_comb begin
    out_data_d = '0;
    if (found_q) begin
      out_data_d = {PadW'(0), WdW'(width_q), ArW'(area_q), PcW'(peak_cnt_q),
                    ChW'(peak_q), ChW'(right_q), ChW'(left_q)};
    end
  end

  spf_store #(
    .DEPTH  (MAX_CHANNELS),
    .ADDR_W (IDX_W),
    .DATA_W (COUNT_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (loaded_q[IDX_W-1:0]),
    .wdata_i (in_cnt),
    .re_i    (rd_en),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  spf_wmul #(
    .A_W (TOT_W)
  ) u_wmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= spf_pkg::FACT_RESET;
      pct_q    <= spf_pkg::PCT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        spf_pkg::CFG_THRESHOLD_FACTOR: factor_q <= cfg_wdata_i[spf_pkg::FACT_W-1:0];
        spf_pkg::CFG_REGION_PERCENT:   pct_q    <= cfg_wdata_i[spf_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // read pipeline payload
  always_ff @(posedge clk_i) begin
    s1_idx_q  <= rd_idx_q[IDX_W-1:0];
    s2_idx_q  <= s1_idx_q;
    s2_c_q    <= rdata;
    s2_prod_q <= PR_W'(rdata) * PR_W'(mop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      loaded_q    <= '0;
      total_q     <= '0;
      rd_idx_q    <= '0;
      rd_end_q    <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      kscale_q    <= '0;
      in_run_q    <= 1'b0;
      found_q     <= 1'b0;
      run_start_q <= '0;
      run_sum_q   <= '0;
      best_lo_q   <= '0;
      best_hi_q   <= '0;
      best_sum_q  <= '0;
      pk_first_q  <= 1'b0;
      peak_q      <= '0;
      peak_cnt_q  <= '0;
      any_q       <= 1'b0;
      left_q      <= '0;
      right_q     <= '0;
      area_q      <= '0;
      width_q     <= '0;
      out_v_q     <= 1'b0;
      out_found_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      s1_v_q <= rd_en;
      s2_v_q <= s1_v_q;
      if (rd_en) begin
        rd_idx_q <= rd_idx_q + N_W'(1);
      end
      // in S_EMIT the result register is handled by the emit arm
      if (m_axis_tready_i && (state_q != S_EMIT)) begin
        out_v_q <= 1'b0;
      end

      case (state_q)
        S_LOAD: begin
          if (store_we) begin
            loaded_q <= loaded_q + N_W'(1);
            total_q  <= total_q + TOT_W'(in_cnt);
          end
          if (in_beat && s_axis_tlast_i) begin
            state_q <= S_TMUL;
          end
        end

        S_TMUL: begin
          kscale_q  <= K_W'(loaded_q) * K_W'(spf_pkg::PCT_SCALE);
          in_run_q  <= 1'b0;
          found_q   <= 1'b0;
          best_lo_q <= '0;
          best_hi_q <= '0;
          best_sum_q <= '0;
          rd_idx_q  <= '0;
          rd_end_q  <= loaded_q;
          state_q   <= S_TWAIT;
        end

        S_TWAIT: begin
          if (mul_done) begin
            state_q <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (s2_v_q) begin
            if (marked) begin
              if (!in_run_q) begin
                in_run_q    <= 1'b1;
                run_start_q <= s2_idx_q;
                run_sum_q   <= TOT_W'(s2_c_q);
              end else begin
                run_sum_q <= run_sum_q + TOT_W'(s2_c_q);
              end
            end else if (in_run_q) begin
              in_run_q <= 1'b0;
              if (!found_q || run_sum_q > best_sum_q) begin
                found_q    <= 1'b1;
                best_lo_q  <= run_start_q;
                best_hi_q  <= s2_idx_q - IDX_W'(1);
                best_sum_q <= run_sum_q;
              end
            end
          end
          if (drained) begin
            state_q <= S_CLOSE;
          end
        end

        S_CLOSE: begin
          // a run still open at the end closes on the last channel
          if (in_run_q) begin
            in_run_q <= 1'b0;
            if (!found_q || run_sum_q > best_sum_q) begin
              found_q    <= 1'b1;
              best_lo_q  <= run_start_q;
              best_hi_q  <= IDX_W'(loaded_q - N_W'(1));
              best_sum_q <= run_sum_q;
            end
          end
          state_q <= (found_q || in_run_q) ? S_RMUL : S_EMIT;
        end

        S_RMUL: begin
          rd_idx_q   <= N_W'(best_lo_q);
          rd_end_q   <= N_W'(best_hi_q) + N_W'(1);
          pk_first_q <= 1'b1;
          any_q      <= 1'b0;
          left_q     <= '0;
          right_q    <= '0;
          area_q     <= '0;
          width_q    <= '0;
          state_q    <= S_RWAIT;
        end

        S_RWAIT: begin
          if (mul_done) begin
            state_q <= S_PEAK;
          end
        end

        S_PEAK: begin
          if (s2_v_q) begin
            pk_first_q <= 1'b0;
            if (pk_first_q || s2_c_q > peak_cnt_q) begin
              peak_q     <= s2_idx_q;
              peak_cnt_q <= s2_c_q;
            end
            if (in_region) begin
              if (!any_q) begin
                left_q <= s2_idx_q;
              end
              any_q   <= 1'b1;
              right_q <= s2_idx_q;
              area_q  <= area_q + TOT_W'(s2_c_q);
              width_q <= width_q + N_W'(1);
            end
          end
          if (drained) begin
            state_q <= S_EMIT;
          end
        end

        S_EMIT: begin
          // hold until the result register is free
          if (out_free) begin
            out_v_q     <= 1'b1;
            out_found_q <= found_q;
            out_data_q  <= out_data_d;
            loaded_q    <= '0;
            total_q     <= '0;
            state_q     <= S_LOAD;
          end
        end

        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_found_q;

  // reads stay inside the channels of the current pass
  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (rd_idx_q < rd_end_q) && (rd_end_q <= loaded_q))
    else $error("spectrum read beyond loaded channels");

  // the fill count never passes the store depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q <= N_W'(MAX_CHANNELS))
    else $error("channel fill count past store depth");

  // peak pass only runs on a spectrum with a best run
  a_peak_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PEAK) |-> found_q && (best_lo_q <= best_hi_q))
    else $error("peak pass without a valid run");

  // a result without a peak carries all-zero fields
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("result without peak has nonzero fields");

  // no new result is loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("pending result overwritten");

endmodule
